### design/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg - sphere contact shared types and constants
// Fixed-point widths, query and contact structs, pipeline context and
// saturation helpers shared by all sphere contact pipeline modules.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int CW   = 32;          // coordinate width
    localparam int FB   = 16;          // fraction bits
    localparam int PW   = CW - 1;      // penetration / radius width
    localparam int DW   = CW + 1;      // center difference width
    localparam int AW   = CW + 2;      // radius sum width
    localparam int SQW  = 2 * DW;      // one squared difference
    localparam int SSW  = SQW + 2;     // sum of three squares, even
    localparam int RTW  = SSW / 2;     // square root width
    localparam int REMW = RTW + 2;     // square root remainder
    localparam int PRW  = 2 * CW;      // dot product term
    localparam int KW   = PRW + 3;     // plane distance, Q.2F
    localparam int RQW  = PW + FB;     // radius in Q.2F
    localparam int XW   = KW + 1;      // wide working width
    localparam int KFW  = KW - FB;     // plane distance, Q.F
    localparam int KLO  = KFW / 2;     // low split of distance
    localparam int KHI  = KFW - KLO;   // high split of distance
    localparam int HW   = CW + KHI;    // high partial product
    localparam int LW   = CW + KLO + 1;// low partial product
    localparam int MW   = CW + KFW;    // full projection product
    localparam int QW   = FB + 1;      // normal quotient width
    localparam int DRW  = RTW + 1;     // divider remainder

    localparam logic [1:0] FN_SPHERE = 2'd0;
    localparam logic [1:0] FN_HALF   = 2'd1;
    localparam logic [1:0] FN_PLANE  = 2'd2;

    localparam logic [CW-1:0] CMAX = {1'b0, {PW{1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {PW{1'b0}}};

    typedef struct packed {
        logic [1:0]           func;
        logic signed [CW-1:0] a_center_x;
        logic signed [CW-1:0] a_center_y;
        logic signed [CW-1:0] a_center_z;
        logic [PW-1:0]        a_radius;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_z;
        logic signed [CW-1:0] b_w;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] normal_x;
        logic signed [CW-1:0] normal_y;
        logic signed [CW-1:0] normal_z;
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
        logic [PW-1:0]        penetration;
    } t_rsp;

    // per-item context: vec is the center difference for spheres and the
    // final normal for planes, aux the radius sum or the plane penetration
    typedef struct packed {
        logic [1:0]          func;
        logic                hit;
        logic [2:0][DW-1:0]  vec;
        logic [2:0][CW-1:0]  pt;
        logic [AW-1:0]       aux;
    } t_ctx;

    function automatic logic [CW-1:0] sat_cw(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = $signed({{(XW-CW){1'b0}}, CMAX});
        lo = $signed({{(XW-CW){1'b1}}, CMIN});
        if (v > hi) begin
            return CMAX;
        end else if (v < lo) begin
            return CMIN;
        end
        return v[CW-1:0];
    endfunction

    function automatic logic [PW-1:0] clamp_pen(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi;
        hi = $signed({{(XW-PW){1'b0}}, {PW{1'b1}}});
        if (v < 0) begin
            return '0;
        end else if (v > hi) begin
            return {PW{1'b1}};
        end
        return v[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] sat_pen(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] s;
        s = v >>> FB;
        return clamp_pen(s);
    endfunction

    function automatic logic [CW-1:0] neg_sat(input logic signed [CW-1:0] v);
        if (v == $signed(CMIN)) begin
            return CMAX;
        end
        return CW'(-v);
    endfunction

endpackage

### design/sphere_primitive_contact.sv
// ----------------------------------------------------------------------------
// sphere_primitive_contact - sphere contact generator
// Sphere against sphere, half-space or two-sided plane in Q16.16, giving
// hit flag, contact normal, contact point and penetration depth.
// ----------------------------------------------------------------------------
// The block takes one query per clock while o_ready is high and returns one
// contact result per query, in order, through six front-end stages (center
// differences, dot product, squares, plane test, projected point), 34 square
// root stages (one root bit each over the 68-bit squared distance), one stage
// for the sphere hit test, 17 divider stages (one normal bit each) and the
// output register. The whole pipeline advances together; it holds in place
// while a result waits at the output and the sink is not ready, so the input
// ready follows the output side. A miss, or selector value three, returns
// all fields zero. The plane normal is used as given and taken as unit length.
// ----------------------------------------------------------------------------
module sphere_primitive_contact (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  spc_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output spc_pkg::t_rsp  o_rsp
);

    // global advance: move when the output register is free or being taken
    logic en;
    logic r_out_v;

    assign en      = !r_out_v || i_ready;
    assign o_ready = en;

    // front end
    logic                      fe_v;
    spc_pkg::t_ctx             fe_ctx;
    logic [spc_pkg::SSW-1:0]   fe_ss;

    spc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_valid (fe_v),
        .o_ctx   (fe_ctx),
        .o_ss    (fe_ss)
    );

    // center distance
    logic                      sq_v;
    spc_pkg::t_ctx             sq_ctx;
    logic [spc_pkg::RTW-1:0]   sq_root;

    spc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fe_v),
        .i_ctx   (fe_ctx),
        .i_ss    (fe_ss),
        .o_valid (sq_v),
        .o_ctx   (sq_ctx),
        .o_root  (sq_root)
    );

    // sphere hit test: root nonzero and below the radius sum
    logic signed [spc_pkg::XW-1:0] rsx;
    logic signed [spc_pkg::XW-1:0] sx;
    logic                          shit;
    spc_pkg::t_ctx                 n_b_ctx;
    logic                          r_b_v;
    spc_pkg::t_ctx                 r_b_ctx;
    logic [spc_pkg::RTW-1:0]       r_b_den;

    always_comb begin
        rsx     = spc_pkg::XW'($signed(sq_ctx.aux));
        sx      = $signed({{(spc_pkg::XW-spc_pkg::RTW){1'b0}}, sq_root});
        shit    = (sq_root != '0) && (sx < rsx);
        n_b_ctx = sq_ctx;
        if (sq_ctx.func == spc_pkg::FN_SPHERE) begin
            n_b_ctx.hit = shit;
            n_b_ctx.aux = {3'b000, spc_pkg::clamp_pen(rsx - sx)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en) begin
            r_b_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_ctx <= n_b_ctx;
            r_b_den <= sq_root;
        end
    end

    // normal = difference / distance
    logic                      dv_v;
    spc_pkg::t_ctx             dv_ctx;
    logic [spc_pkg::QW-1:0]    dv_q [3];

    spc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_v),
        .i_ctx   (r_b_ctx),
        .i_den   (r_b_den),
        .o_valid (dv_v),
        .o_ctx   (dv_ctx),
        .o_q     (dv_q)
    );

    // output formatting: pick normal source, zero everything on a miss
    logic [spc_pkg::CW-1:0]   nrm [3];
    logic signed [spc_pkg::CW-1:0] qs [3];
    spc_pkg::t_rsp            n_out;
    spc_pkg::t_rsp            r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qs[i] = $signed({{(spc_pkg::CW-spc_pkg::QW){1'b0}}, dv_q[i]});
            if (dv_ctx.func == spc_pkg::FN_SPHERE) begin
                nrm[i] = dv_ctx.vec[i][spc_pkg::DW-1] ? spc_pkg::CW'(-qs[i])
                                                      : spc_pkg::CW'(qs[i]);
            end else begin
                nrm[i] = dv_ctx.vec[i][spc_pkg::CW-1:0];
            end
        end
        n_out = '0;
        if (dv_ctx.hit) begin
            n_out.hit         = 1'b1;
            n_out.normal_x    = nrm[0];
            n_out.normal_y    = nrm[1];
            n_out.normal_z    = nrm[2];
            n_out.point_x     = dv_ctx.pt[0];
            n_out.point_y     = dv_ctx.pt[1];
            n_out.point_z     = dv_ctx.pt[2];
            n_out.penetration = dv_ctx.aux[spc_pkg::PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_rsp   = r_out;

endmodule

### design/spc_front.sv
// ----------------------------------------------------------------------------
// spc_front - query front end
// Center differences and squares for spheres, plane distance, plane hit test
// and projected contact point, over six register stages.
// ----------------------------------------------------------------------------
module spc_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  spc_pkg::t_req            i_req,
    output logic                     o_valid,
    output spc_pkg::t_ctx            o_ctx,
    output logic [spc_pkg::SSW-1:0]  o_ss
);

    // stage 1: differences and dot product terms
    logic signed [spc_pkg::CW-1:0]  a_in [3];
    logic signed [spc_pkg::CW-1:0]  b_in [3];
    logic                           r1_v;
    logic [1:0]                     r1_func;
    logic signed [spc_pkg::CW-1:0]  r1_a [3];
    logic signed [spc_pkg::CW-1:0]  r1_b [3];
    logic signed [spc_pkg::DW-1:0]  r1_d [3];
    logic signed [spc_pkg::PRW-1:0] r1_p [3];
    logic [spc_pkg::PW-1:0]         r1_r;
    logic signed [spc_pkg::CW-1:0]  r1_bw;

    assign a_in[0] = i_req.a_center_x;
    assign a_in[1] = i_req.a_center_y;
    assign a_in[2] = i_req.a_center_z;
    assign b_in[0] = i_req.b_x;
    assign b_in[1] = i_req.b_y;
    assign b_in[2] = i_req.b_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_func <= i_req.func;
            r1_r    <= i_req.a_radius;
            r1_bw   <= i_req.b_w;
            for (int i = 0; i < 3; i++) begin
                r1_a[i] <= a_in[i];
                r1_b[i] <= b_in[i];
                r1_d[i] <= spc_pkg::DW'(a_in[i]) - spc_pkg::DW'(b_in[i]);
                r1_p[i] <= spc_pkg::PRW'(a_in[i]) * spc_pkg::PRW'(b_in[i]);
            end
        end
    end

    // stage 2: squares, plane distance, sphere point, radius sum
    logic [spc_pkg::DW-1:0]         absd [3];
    logic signed [spc_pkg::XW-1:0]  hsum [3];
    logic signed [spc_pkg::KW-1:0]  n2_k;
    logic                           r2_v;
    logic [1:0]                     r2_func;
    logic signed [spc_pkg::CW-1:0]  r2_a [3];
    logic signed [spc_pkg::CW-1:0]  r2_b [3];
    logic signed [spc_pkg::DW-1:0]  r2_d [3];
    logic [spc_pkg::SQW-1:0]        r2_sq [3];
    logic [spc_pkg::CW-1:0]         r2_spt [3];
    logic signed [spc_pkg::KW-1:0]  r2_k;
    logic [spc_pkg::RQW-1:0]        r2_rq;
    logic signed [spc_pkg::AW-1:0]  r2_rsum;

    always_comb begin
        n2_k = -(spc_pkg::KW'(r1_bw) <<< spc_pkg::FB);
        for (int i = 0; i < 3; i++) begin
            absd[i] = r1_d[i][spc_pkg::DW-1] ? spc_pkg::DW'(-r1_d[i]) : r1_d[i];
            hsum[i] = spc_pkg::XW'(r1_a[i]) + spc_pkg::XW'(r1_d[i] >>> 1);
            n2_k    = n2_k + spc_pkg::KW'(r1_p[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_func <= r1_func;
            r2_k    <= n2_k;
            r2_rq   <= {r1_r, {spc_pkg::FB{1'b0}}};
            r2_rsum <= $signed({3'b000, r1_r}) + spc_pkg::AW'(r1_bw);
            for (int i = 0; i < 3; i++) begin
                r2_a[i]   <= r1_a[i];
                r2_b[i]   <= r1_b[i];
                r2_d[i]   <= r1_d[i];
                r2_sq[i]  <= spc_pkg::SQW'(absd[i]) * spc_pkg::SQW'(absd[i]);
                r2_spt[i] <= spc_pkg::sat_cw(hsum[i]);
            end
        end
    end

    // stage 3: sum of squares, plane hit test and penetration
    logic signed [spc_pkg::XW-1:0]  rqx;
    logic signed [spc_pkg::XW-1:0]  kx;
    logic signed [spc_pkg::XW-1:0]  nbd;
    logic signed [spc_pkg::XW-1:0]  dp;
    logic                           kneg;
    logic                           sph;
    logic                           phit;
    logic [spc_pkg::PW-1:0]         ppen;
    spc_pkg::t_ctx                  n3_ctx;
    logic                           r3_v;
    spc_pkg::t_ctx                  r3_ctx;
    logic signed [spc_pkg::CW-1:0]  r3_a [3];
    logic signed [spc_pkg::CW-1:0]  r3_b [3];
    logic [spc_pkg::SSW-1:0]        r3_ss;
    logic [spc_pkg::KFW-1:0]        r3_kf;

    always_comb begin
        rqx  = $signed({{(spc_pkg::XW-spc_pkg::RQW){1'b0}}, r2_rq});
        kx   = spc_pkg::XW'(r2_k);
        kneg = r2_k[spc_pkg::KW-1];
        nbd  = rqx - kx;
        dp   = kneg ? rqx + kx : rqx - kx;
        sph  = (r2_func == spc_pkg::FN_SPHERE);
        phit = 1'b0;
        ppen = spc_pkg::sat_pen(dp);
        if (r2_func == spc_pkg::FN_HALF) begin
            phit = !nbd[spc_pkg::XW-1] && (nbd != '0);
            ppen = spc_pkg::sat_pen(nbd);
        end else if (r2_func == spc_pkg::FN_PLANE) begin
            phit = !dp[spc_pkg::XW-1];
        end
        n3_ctx.func = r2_func;
        n3_ctx.hit  = phit;
        n3_ctx.aux  = sph ? r2_rsum : {3'b000, ppen};
        for (int i = 0; i < 3; i++) begin
            n3_ctx.pt[i] = r2_spt[i];
            if (sph) begin
                n3_ctx.vec[i] = r2_d[i];
            end else if (r2_func == spc_pkg::FN_PLANE && kneg) begin
                n3_ctx.vec[i] = spc_pkg::DW'($signed(spc_pkg::neg_sat(r2_b[i])));
            end else begin
                n3_ctx.vec[i] = spc_pkg::DW'(r2_b[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ctx <= n3_ctx;
            r3_ss  <= spc_pkg::SSW'(r2_sq[0]) + spc_pkg::SSW'(r2_sq[1])
                    + spc_pkg::SSW'(r2_sq[2]);
            r3_kf  <= r2_k[spc_pkg::KW-1:spc_pkg::FB];
            for (int i = 0; i < 3; i++) begin
                r3_a[i] <= r2_a[i];
                r3_b[i] <= r2_b[i];
            end
        end
    end

    // stage 4: normal times distance, split in two partial products
    logic                           r4_v;
    spc_pkg::t_ctx                  r4_ctx;
    logic signed [spc_pkg::CW-1:0]  r4_a [3];
    logic [spc_pkg::SSW-1:0]        r4_ss;
    logic signed [spc_pkg::HW-1:0]  r4_ph [3];
    logic signed [spc_pkg::LW-1:0]  r4_pl [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ctx <= r3_ctx;
            r4_ss  <= r3_ss;
            for (int i = 0; i < 3; i++) begin
                r4_a[i]  <= r3_a[i];
                r4_ph[i] <= spc_pkg::HW'(r3_b[i])
                          * spc_pkg::HW'($signed(r3_kf[spc_pkg::KFW-1:spc_pkg::KLO]));
                r4_pl[i] <= spc_pkg::LW'(r3_b[i])
                          * $signed({1'b0, r3_kf[spc_pkg::KLO-1:0]});
            end
        end
    end

    // stage 5: recombine partial products
    logic                           r5_v;
    spc_pkg::t_ctx                  r5_ctx;
    logic signed [spc_pkg::CW-1:0]  r5_a [3];
    logic [spc_pkg::SSW-1:0]        r5_ss;
    logic signed [spc_pkg::MW-1:0]  r5_m [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (i_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_ctx <= r4_ctx;
            r5_ss  <= r4_ss;
            for (int i = 0; i < 3; i++) begin
                r5_a[i] <= r4_a[i];
                r5_m[i] <= (spc_pkg::MW'(r4_ph[i]) <<< spc_pkg::KLO)
                         + spc_pkg::MW'(r4_pl[i]);
            end
        end
    end

    // stage 6: plane point = center minus projection
    spc_pkg::t_ctx                  n6_ctx;
    logic signed [spc_pkg::XW-1:0]  pdif [3];
    logic                           r6_v;
    spc_pkg::t_ctx                  r6_ctx;
    logic [spc_pkg::SSW-1:0]        r6_ss;

    always_comb begin
        n6_ctx = r5_ctx;
        for (int i = 0; i < 3; i++) begin
            pdif[i] = spc_pkg::XW'(r5_a[i])
                    - spc_pkg::XW'($signed(r5_m[i][spc_pkg::MW-1:spc_pkg::FB]));
            if (r5_ctx.func != spc_pkg::FN_SPHERE) begin
                n6_ctx.pt[i] = spc_pkg::sat_cw(pdif[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (i_en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_ctx <= n6_ctx;
            r6_ss  <= r5_ss;
        end
    end

    assign o_valid = r6_v;
    assign o_ctx   = r6_ctx;
    assign o_ss    = r6_ss;

endmodule

### design/spc_sqrt.sv
// ----------------------------------------------------------------------------
// spc_sqrt - pipelined integer square root
// Floor square root of the squared center distance, one root bit per stage.
// ----------------------------------------------------------------------------
module spc_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  spc_pkg::t_ctx            i_ctx,
    input  logic [spc_pkg::SSW-1:0]  i_ss,
    output logic                     o_valid,
    output spc_pkg::t_ctx            o_ctx,
    output logic [spc_pkg::RTW-1:0]  o_root
);

    localparam int N = spc_pkg::RTW;

    logic                        r_v    [N];
    spc_pkg::t_ctx               r_ctx  [N];
    logic [spc_pkg::SSW-1:0]     r_rad  [N];
    logic [spc_pkg::REMW-1:0]    r_rem  [N];
    logic [spc_pkg::RTW-1:0]     r_root [N];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            logic                        v_in;
            spc_pkg::t_ctx               ctx_in;
            logic [spc_pkg::SSW-1:0]     rad_in;
            logic [spc_pkg::REMW-1:0]    rem_in;
            logic [spc_pkg::RTW-1:0]     root_in;
            logic [spc_pkg::REMW+1:0]    n_sh;
            logic [spc_pkg::REMW+1:0]    n_trial;
            logic                        n_take;

            if (g == 0) begin : g_first
                assign v_in    = i_valid;
                assign ctx_in  = i_ctx;
                assign rad_in  = i_ss;
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_next
                assign v_in    = r_v[g-1];
                assign ctx_in  = r_ctx[g-1];
                assign rad_in  = r_rad[g-1];
                assign rem_in  = r_rem[g-1];
                assign root_in = r_root[g-1];
            end

            // bring down two radicand bits, try root*4+1
            assign n_sh    = {rem_in, rad_in[spc_pkg::SSW-1 -: 2]};
            assign n_trial = {{(spc_pkg::REMW-spc_pkg::RTW){1'b0}}, root_in, 2'b01};
            assign n_take  = (n_sh >= n_trial);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (i_en) begin
                    r_v[g] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ctx[g]  <= ctx_in;
                    r_rad[g]  <= {rad_in[spc_pkg::SSW-3:0], 2'b00};
                    r_rem[g]  <= n_take ? spc_pkg::REMW'(n_sh - n_trial)
                                        : n_sh[spc_pkg::REMW-1:0];
                    r_root[g] <= {root_in[spc_pkg::RTW-2:0], n_take};
                end
            end
        end
    endgenerate

    assign o_valid = r_v[N-1];
    assign o_ctx   = r_ctx[N-1];
    assign o_root  = r_root[N-1];

endmodule

### design/spc_div.sv
// ----------------------------------------------------------------------------
// spc_div - pipelined normal divider
// Three restoring divider lanes, |d| * 2^F / root, one quotient bit per stage.
// ----------------------------------------------------------------------------
module spc_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  spc_pkg::t_ctx            i_ctx,
    input  logic [spc_pkg::RTW-1:0]  i_den,
    output logic                     o_valid,
    output spc_pkg::t_ctx            o_ctx,
    output logic [spc_pkg::QW-1:0]   o_q [3]
);

    localparam int N = spc_pkg::QW;

    logic                        r_v   [N];
    spc_pkg::t_ctx               r_ctx [N];
    logic [spc_pkg::RTW-1:0]     r_den [N];
    logic [spc_pkg::DRW-1:0]     r_rem [N][3];
    logic [spc_pkg::QW-1:0]      r_q   [N][3];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            logic                        v_in;
            spc_pkg::t_ctx               ctx_in;
            logic [spc_pkg::RTW-1:0]     den_in;
            logic [spc_pkg::DRW:0]       n_sh   [3];
            logic [spc_pkg::QW-1:0]      q_in   [3];
            logic [spc_pkg::DRW:0]       n_den;
            logic signed [spc_pkg::DW-1:0] vs   [3];

            if (g == 0) begin : g_first
                assign v_in   = i_valid;
                assign ctx_in = i_ctx;
                assign den_in = i_den;
                // integer step: magnitude of the difference, no shift
                always_comb begin
                    for (int i = 0; i < 3; i++) begin
                        vs[i]   = $signed(i_ctx.vec[i]);
                        n_sh[i] = vs[i][spc_pkg::DW-1]
                                ? (spc_pkg::DRW+1)'(spc_pkg::DW'(-vs[i]))
                                : (spc_pkg::DRW+1)'(i_ctx.vec[i]);
                        q_in[i] = '0;
                    end
                end
            end else begin : g_next
                assign v_in   = r_v[g-1];
                assign ctx_in = r_ctx[g-1];
                assign den_in = r_den[g-1];
                always_comb begin
                    for (int i = 0; i < 3; i++) begin
                        vs[i]   = '0;
                        n_sh[i] = {r_rem[g-1][i], 1'b0};
                        q_in[i] = r_q[g-1][i];
                    end
                end
            end

            assign n_den = {{(spc_pkg::DRW+1-spc_pkg::RTW){1'b0}}, den_in};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (i_en) begin
                    r_v[g] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ctx[g] <= ctx_in;
                    r_den[g] <= den_in;
                    for (int i = 0; i < 3; i++) begin
                        if (n_sh[i] >= n_den) begin
                            r_rem[g][i] <= spc_pkg::DRW'(n_sh[i] - n_den);
                            r_q[g][i]   <= {q_in[i][spc_pkg::QW-2:0], 1'b1};
                        end else begin
                            r_rem[g][i] <= n_sh[i][spc_pkg::DRW-1:0];
                            r_q[g][i]   <= {q_in[i][spc_pkg::QW-2:0], 1'b0};
                        end
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_v[N-1];
    assign o_ctx   = r_ctx[N-1];
    assign o_q[0]  = r_q[N-1][0];
    assign o_q[1]  = r_q[N-1][1];
    assign o_q[2]  = r_q[N-1][2];

endmodule
